@@ sv/lphs_pkg.sv @@
// Shared constants and types for the linear-probing hash set.
`timescale 1ns / 1ps
package lphs_pkg;

  localparam int unsigned CAPACITY  = 1024;
  localparam int unsigned KEY_BITS  = 32;
  localparam int unsigned HASH_BITS = 32;
  localparam int unsigned SLOT_W    = $clog2(CAPACITY);
  localparam int unsigned SIZE_W    = SLOT_W + 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(53);

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  localparam logic [1:0] OP_SEARCH = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_ABSENT = 2'd2;

  typedef struct packed {
    logic [1:0]          mark;
    logic [KEY_BITS-1:0] key;
  } slot_t;

endpackage

@@ sv/lphs_rem.sv @@
// Bit-serial remainder unit that reduces the hash modulo the table size.
`timescale 1ns / 1ps
module lphs_rem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [lphs_pkg::HASH_BITS-1:0]  dividend_i,
  input  logic [lphs_pkg::SIZE_W-1:0]     divisor_i,
  output logic                            done_o,
  output logic [lphs_pkg::SLOT_W-1:0]     rem_o
);
  import lphs_pkg::*;

  localparam int unsigned CNT_W = $clog2(HASH_BITS);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [HASH_BITS-1:0] dvd_q, dvd_d;
  logic [SIZE_W-1:0]    div_q, div_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;
  logic [SIZE_W:0]      trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[HASH_BITS-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = SIZE_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[SIZE_W-1:0];
      end
      dvd_d = {dvd_q[HASH_BITS-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(HASH_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[SLOT_W-1:0];

endmodule

@@ sv/lphs_slot_ram.sv @@
// Slot memory holding each slot's mark and key, one write and one registered read per cycle.
`timescale 1ns / 1ps
module lphs_slot_ram (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [lphs_pkg::SLOT_W-1:0] wr_addr_i,
  input  lphs_pkg::slot_t             wr_data_i,
  input  logic [lphs_pkg::SLOT_W-1:0] rd_addr_i,
  output lphs_pkg::slot_t             rd_data_o
);
  import lphs_pkg::*;

  slot_t mem [CAPACITY];
  slot_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

@@ sv/linear_probe_hash_set.sv @@
// Top level of the linear-probing hash set: request control, probe walk and result register.
`timescale 1ns / 1ps
// After reset the block sweeps the slot memory once to mark every slot empty;
// configuration writes are taken during the sweep but no request is accepted.
// For a request, the home slot comes from a bit-serial remainder unit that reduces the hash,
// the walk reads one slot per cycle from the slot memory, and a done state moves the result
// to the output register once that register is free.
// One request is worked on at a time, and a new request is accepted while the previous
// result still waits in the output register.
// Table size is sampled from the configuration register, with zero taken as one and values
// above 1024 taken as 1024; it may only be changed while the block is idle.
module linear_probe_hash_set (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // key [31:0], hash_value [63:32]
  input  logic [1:0]  s_axis_tuser,  // operation [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // found [0], status [2:1], slot_index [12:3],
                                     // entry_count [23:13]
);
  import lphs_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [SIZE_W-1:0]   size_q, size_eff;
  logic [SLOT_W-1:0]   clr_q, clr_d;
  logic [SLOT_W-1:0]   p_q, p_d;
  logic [SIZE_W-1:0]   n_q, n_d;
  logic [SIZE_W-1:0]   live_q, live_d;
  logic [1:0]          op_q, op_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic                res_found_q, res_found_d;
  logic [1:0]          res_status_q, res_status_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic                m_valid_q, m_valid_d;
  logic [23:0]         m_data_q, m_data_d;

  logic                accept;
  logic                rem_done;
  logic [SLOT_W-1:0]   rem_val;
  logic                we;
  logic [SLOT_W-1:0]   wa;
  slot_t               wd;
  slot_t               rd;
  logic [SIZE_W-1:0]   p_inc;
  logic [SLOT_W-1:0]   p_next;
  logic                walk_last;
  logic                key_hit;

  always_comb begin
    size_eff = size_q;
    if (size_q == '0) begin
      size_eff = SIZE_W'(1);
    end else if (size_q > SIZE_W'(CAPACITY)) begin
      size_eff = SIZE_W'(CAPACITY);
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  lphs_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (s_axis_tdata[63:32]),
    .divisor_i  (size_eff),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  lphs_slot_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (we),
    .wr_addr_i (wa),
    .wr_data_i (wd),
    .rd_addr_i (p_d),
    .rd_data_o (rd)
  );

  assign p_inc     = {1'b0, p_q} + SIZE_W'(1);
  assign p_next    = (p_inc >= size_eff) ? '0 : p_inc[SLOT_W-1:0];
  assign walk_last = ((n_q + SIZE_W'(1)) == size_eff);
  assign key_hit   = (rd.mark == MARK_LIVE) && (rd.key == key_q);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    p_d          = p_q;
    n_d          = n_q;
    live_d       = live_q;
    op_d         = op_q;
    key_d        = key_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    we           = 1'b0;
    wa           = p_q;
    wd           = '{mark: MARK_EMPTY, key: '0};

    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        wa    = clr_q;
        clr_d = clr_q + SLOT_W'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d    = s_axis_tuser;
          key_d   = s_axis_tdata[31:0];
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (rem_done) begin
          p_d          = rem_val;
          n_d          = '0;
          res_found_d  = 1'b0;
          res_status_d = STAT_OK;
          res_slot_d   = '0;
          state_d      = S_WALK;
        end
      end
      S_WALK: begin
        unique case (op_q)
          OP_SEARCH, OP_REMOVE: begin
            if (rd.mark == MARK_EMPTY || (!key_hit && walk_last)) begin
              res_status_d = (op_q == OP_REMOVE) ? STAT_ABSENT : STAT_OK;
              state_d      = S_DONE;
            end else if (key_hit) begin
              res_found_d = 1'b1;
              res_slot_d  = p_q;
              if (op_q == OP_REMOVE) begin
                we     = 1'b1;
                wd     = '{mark: MARK_TOMB, key: rd.key};
                live_d = live_q - SIZE_W'(1);
              end
              state_d = S_DONE;
            end else begin
              p_d = p_next;
              n_d = n_q + SIZE_W'(1);
            end
          end
          OP_INSERT: begin
            if (rd.mark != MARK_LIVE) begin
              we          = 1'b1;
              wd          = '{mark: MARK_LIVE, key: key_q};
              live_d      = live_q + SIZE_W'(1);
              res_found_d = 1'b1;
              res_slot_d  = p_q;
              state_d     = S_DONE;
            end else if (walk_last) begin
              res_status_d = STAT_FULL;
              state_d      = S_DONE;
            end else begin
              p_d = p_next;
              n_d = n_q + SIZE_W'(1);
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {live_q, res_slot_q, res_status_q, res_found_q};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      size_q    <= SIZE_RESET;
      clr_q     <= '0;
      live_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      live_q    <= live_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q          <= p_d;
    n_q          <= n_d;
    op_q         <= op_d;
    key_q        <= key_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    m_data_q     <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the linear-probing hash set with a shadow table model.
`timescale 1ns / 1ps
module testbench;
  import lphs_pkg::*;

  localparam logic [1:0]  OP_NONE        = 2'd3;
  localparam int unsigned LIMIT_CYCLES   = 2_000_000;
  localparam int unsigned HOLD_OFF       = 600;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [10:0] count;
    logic [9:0]  slot;
    logic [1:0]  status;
    logic        found;
  } outcome_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [10:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = OP_SEARCH;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  logic [KEY_BITS-1:0] shadow_key  [CAPACITY];
  logic [1:0]          shadow_mark [CAPACITY];
  logic [10:0]         shadow_live;
  logic [10:0]         shadow_size;

  outcome_t            pending_outcomes [$];
  logic [31:0]         key_pool [$];
  int unsigned         mismatches  = 0;
  int unsigned         cycle_count = 0;
  logic                gaps_on     = 1'b1;
  int unsigned         holds_asked = 0;
  int unsigned         holds_done  = 0;
  int unsigned         hold_left   = 0;
  int unsigned         stall_left  = 0;
  int unsigned         rx_gap;

  linear_probe_hash_set uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int find_live_slot(logic [31:0] key, int unsigned home,
                                        int unsigned size);
    int unsigned p;
    int unsigned n;
    p = home;
    for (n = 0; n < size; n++) begin
      if (shadow_mark[p] == MARK_EMPTY) return -1;
      if (shadow_mark[p] == MARK_LIVE && shadow_key[p] == key) return int'(p);
      p = (p + 1 == size) ? 0 : p + 1;
    end
    return -1;
  endfunction

  function automatic outcome_t probe_outcome(logic [1:0] op, logic [31:0] key,
                                             logic [31:0] hash);
    outcome_t    res;
    int unsigned size;
    int unsigned home;
    int unsigned p;
    int unsigned n;
    int          hit;
    res  = '0;
    size = shadow_size;
    if (size == 0) size = 1;
    if (size > CAPACITY) size = CAPACITY;
    home = hash % size;
    case (op)
      OP_SEARCH: begin
        hit = find_live_slot(key, home, size);
        if (hit >= 0) begin
          res.found = 1'b1;
          res.slot  = hit[9:0];
        end
      end
      OP_INSERT: begin
        p = home;
        res.status = STAT_FULL;
        for (n = 0; n < size; n++) begin
          if (shadow_mark[p] != MARK_LIVE) begin
            shadow_key[p]  = key;
            shadow_mark[p] = MARK_LIVE;
            shadow_live    = shadow_live + 11'd1;
            res.found      = 1'b1;
            res.status     = STAT_OK;
            res.slot       = p[9:0];
            break;
          end
          p = (p + 1 == size) ? 0 : p + 1;
        end
      end
      OP_REMOVE: begin
        hit = find_live_slot(key, home, size);
        if (hit >= 0) begin
          shadow_mark[hit] = MARK_TOMB;
          shadow_live      = shadow_live - 11'd1;
          res.found        = 1'b1;
          res.slot         = hit[9:0];
        end else begin
          res.status = STAT_ABSENT;
        end
      end
      default: ;
    endcase
    res.count = shadow_live;
    return res;
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [31:0] key,
                              input logic [31:0] hash);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hash, key};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_outcomes.push_back(probe_outcome(op, key, hash));
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_request();
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] hash;
    int unsigned r;
    r  = $urandom_range(99);
    op = (r < 35) ? OP_INSERT : (r < 65) ? OP_SEARCH : (r < 95) ? OP_REMOVE : OP_NONE;
    if ($urandom_range(99) < 85) begin
      key  = key_pool[$urandom_range(key_pool.size() - 1)];
      hash = ($urandom_range(9) == 0) ? $urandom() : (key * 32'h9E3779B1) ^ (key >> 13);
    end else begin
      key  = $urandom();
      hash = $urandom();
    end
    send_request(op, key, hash);
  endtask

  // The table size may only change once every request has produced its result.
  task automatic write_table_size(input logic [10:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_size = value;
  endtask

  task automatic run_phase(input logic [10:0] size, input int unsigned count);
    int unsigned pool_n;
    write_table_size(size);
    gaps_on <= ($urandom_range(3) != 0);
    pool_n = (int'(size) * 2 + 2 > 48) ? 48 : int'(size) * 2 + 2;
    key_pool.delete();
    repeat (pool_n) key_pool.push_back($urandom());
    repeat (count) send_random_request();
  endtask

  task automatic test_reset_size_ops();
    send_request(OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0001_2345, 32'h0000_0000);
    send_request(OP_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'hA5A5_A5A5, 32'h0000_0000);
  endtask

  // A zero size acts as one slot, and sizes above the capacity saturate.
  task automatic test_size_extremes();
    write_table_size(11'd0);
    send_request(OP_SEARCH, 32'hA5A5_A5A5, 32'h8000_0001);
    send_request(OP_REMOVE, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_request(OP_INSERT, 32'h1234_5678, 32'h7FFF_FFFE);
    send_request(OP_INSERT, 32'h8765_4321, 32'h0000_0003);
    send_request(OP_SEARCH, 32'h8765_4321, 32'hC000_0000);
    send_request(OP_REMOVE, 32'h1234_5678, 32'h0000_0001);
    send_request(OP_SEARCH, 32'h1234_5678, 32'h0000_0001);
    write_table_size(11'd2047);
    send_request(OP_INSERT, 32'h5555_AAAA, 32'hFFFF_FFFF);
    send_request(OP_SEARCH, 32'h5555_AAAA, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 32'h5555_AAAA, 32'hFFFF_FFFF);
  endtask

  task automatic test_output_backpressure();
    write_table_size(11'd53);
    gaps_on     <= 1'b0;
    holds_asked <= holds_asked + 1;
    repeat (12) send_request($urandom_range(1) ? OP_INSERT : OP_SEARCH, $urandom(), $urandom());
  endtask

  task automatic test_random_mix();
    run_phase(11'd53,   180);
    run_phase(11'd13,   150);
    run_phase(11'd251,  150);
    run_phase(11'd3,    80);
    run_phase(11'd1021, 80);
    run_phase(11'd7,    120);
    run_phase(11'd97,   150);
    run_phase(11'd1,    40);
    run_phase(11'd1024, 80);
    run_phase(11'd31,   150);
    run_phase(11'd2,    60);
    run_phase(11'd2047, 40);
  endtask

  always @(posedge clk_i) begin : receiver
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done    <= holds_asked;
      hold_left     <= HOLD_OFF;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      rx_gap = pick_gap();
      if (rx_gap != 0) begin
        stall_left    <= rx_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    outcome_t got;
    outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = outcome_t'(m_axis_tdata);
      if (pending_outcomes.size() == 0) begin
        if (mismatches < REPORT_LIMIT) $display("unexpected result %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        if (got.found !== want.found || got.status !== want.status ||
            got.slot !== want.slot || got.count !== want.count) begin
          if (mismatches < REPORT_LIMIT)
            $display("mismatch (exp/act): found %0d/%0d status %0d/%0d slot %0d/%0d count %0d/%0d",
                     want.found, got.found, want.status, got.status,
                     want.slot, got.slot, want.count, got.count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < CAPACITY; i++) shadow_mark[i] = MARK_EMPTY;
    shadow_live = '0;
    shadow_size = SIZE_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_size_ops();
    test_size_extremes();
    test_output_backpressure();
    test_random_mix();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
